// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  // Field widths of the channels.
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int POS_W     = 11;
  localparam int ENTRY_W   = 16;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;
  localparam logic [ENTRY_W-1:0] RESET_CELL = 16'h0720;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
    logic out_busy;
  } sts_t;

  function automatic logic [ENTRY_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [COLOR_W-1:0] fg,
                                                   input logic [COLOR_W-1:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t      cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       booting;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = req_valid && (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_sweep ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        // The last sweep write lands in this cycle.
        state_next = booting ? ST_IDLE : ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_SWEEP;
      booting <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_DRAIN) booting <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_datapath.sv =====
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::sts_t                         sts,
  input  wire logic                             cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
  input  wire logic [tcw_pkg::REQ_W-1:0]        req_type,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  wire logic [tcw_pkg::IDX_W-1:0]        cell_index,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic [tcw_pkg::POS_W-1:0]             cursor_pos,
  output logic [tcw_pkg::ENTRY_W-1:0]           read_entry
);
  import tcw_pkg::*;

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int COPY_CNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [ENTRY_W-1:0] mem [CELLS];
  logic [ENTRY_W-1:0] rdata;

  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;

  logic [REQ_W-1:0]   cur_req;
  logic [CHAR_W-1:0]  cur_char;
  logic [IDX_W-1:0]   cur_idx;

  logic [ADDR_W-1:0]  ptr;
  logic               sweep_scroll;
  logic [ENTRY_W-1:0] sweep_blank;
  logic               wp_valid;
  logic [ADDR_W-1:0]  wp_addr;
  logic               wp_copy;

  logic [ENTRY_W-1:0] blank;
  logic [ADDR_W-1:0]  cur_addr;
  logic               is_put;
  logic               is_nl;
  logic               is_bs;
  logic               is_print;
  logic               at_bottom;
  logic               new_row;
  logic               sweep_copy;
  logic               in_range;
  logic               exec_we;
  logic [ADDR_W-1:0]  exec_waddr;
  logic [ENTRY_W-1:0] exec_wdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  rd_addr;

  assign blank     = make_cell(CH_SPACE, fg, bg);
  assign cur_addr  = ADDR_W'(int'(row) * COLUMNS + int'(col));
  assign is_put    = (cur_req == REQ_PUT);
  assign is_nl     = (cur_char == CH_NEWLINE);
  assign is_bs     = (cur_char == CH_BACKSPACE);
  assign is_print  = !is_nl && !is_bs && (cur_char != CH_RETURN);
  assign at_bottom = (row == LAST_ROW);
  assign new_row   = is_put && (is_nl || (is_print && col == LAST_COL));
  assign in_range  = int'(cur_idx) < CELLS;

  assign sts.need_sweep = (new_row && at_bottom) || (cur_req == REQ_CLEAR);
  assign sts.sweep_last = (ptr == ADDR_W'(CELLS - 1));
  assign sts.out_busy   = rsp_valid && !rsp_ready;

  // A scroll sweep copies row r+1 into row r, then blanks the bottom row.
  assign sweep_copy = sweep_scroll && (int'(ptr) < COPY_CNT);
  assign rd_addr    = (cmd.sweep && sweep_copy) ? ADDR_W'(int'(ptr) + COLUMNS)
                                                : ADDR_W'(cur_idx);

  assign exec_we    = cmd.exec && is_put && (is_print || (is_bs && col != '0));
  assign exec_waddr = is_bs ? cur_addr - ADDR_W'(1) : cur_addr;
  assign exec_wdata = is_bs ? blank : make_cell(cur_char, fg, bg);

  assign mem_we    = exec_we || wp_valid;
  assign mem_waddr = wp_valid ? wp_addr : exec_waddr;
  assign mem_wdata = wp_valid ? (wp_copy ? rdata : sweep_blank) : exec_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg           <= FG_RESET;
      bg           <= BG_RESET;
      row          <= '0;
      col          <= '0;
      ptr          <= '0;
      sweep_scroll <= 1'b0;
      sweep_blank  <= RESET_CELL;
      wp_valid     <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FG:  fg <= cfg_data;
          CFG_BG:  bg <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (cur_req)
          REQ_PUT: begin
            if (new_row) begin
              col <= '0;
              if (!at_bottom) row <= row + ROW_W'(1);
            end else if (cur_char == CH_RETURN) begin
              col <= '0;
            end else if (is_bs) begin
              if (col != '0) col <= col - COL_W'(1);
            end else begin
              col <= col + COL_W'(1);
            end
          end
          REQ_CLEAR: begin
            row <= '0;
            col <= '0;
          end
          default: ;
        endcase
        if (sts.need_sweep) begin
          ptr          <= '0;
          sweep_scroll <= (cur_req != REQ_CLEAR);
          sweep_blank  <= blank;
        end
      end
      if (cmd.sweep) ptr <= ptr + ADDR_W'(1);
      wp_valid <= cmd.sweep;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_req  <= req_type;
      cur_char <= char_code;
      cur_idx  <= cell_index;
    end
    if (cmd.sweep) begin
      wp_addr <= ptr;
      wp_copy <= sweep_copy;
    end
    if (cmd.publish) begin
      cursor_pos <= POS_W'(int'(row) * COLUMNS + int'(col));
      read_entry <= (cur_req == REQ_READ && in_range) ? rdata : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
`default_nettype none

// Channel   Handshake              Payload
// req       req_valid/req_ready    req_type, char_code, cell_index
// rsp       rsp_valid/rsp_ready    cursor_pos, read_entry
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Put, read and unused requests pass the execute and finish states back to idle.
// Newline at the bottom row, wrap at the bottom row and clear run one sweep over
// the cell memory, one cell a cycle. After reset the memory is filled with blank
// cells before the first item is taken; configuration writes are taken throughout.
// A result waiting on rsp_ready holds the next item in its final cycle.

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic [tcw_pkg::REQ_W-1:0]        req_type,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  wire logic [tcw_pkg::IDX_W-1:0]        cell_index,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic [tcw_pkg::POS_W-1:0]             cursor_pos,
  output logic [tcw_pkg::ENTRY_W-1:0]           read_entry,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);
  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .char_code  (char_code),
    .cell_index (cell_index),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .cursor_pos (cursor_pos),
    .read_entry (read_entry)
  );

  // No item is taken while the memory sweep runs.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !req_ready)
    else $error("item accepted during memory sweep");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(rsp_valid && !rsp_ready))
    else $error("result overwritten while waiting");

  // The reset fill runs before the first item is taken.
  a_boot_fill: assert property (@(posedge clk)
    $fell(rst) |-> (!req_ready && cmd.sweep))
    else $error("item taken before reset fill finished");

  // Execution follows in the cycle after an item is accepted.
  a_exec_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("accepted item was not executed");

endmodule

`default_nettype wire
